### hdl/tlv_header_walker_assert.svh
// assertion macros shared by the walker rtl
`ifndef TLV_HEADER_WALKER_ASSERT_SVH
`define TLV_HEADER_WALKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TLV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlv header walker: implication check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TLV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlv header walker: next-cycle check failed");

`endif

### hdl/tlvhw_pkg.sv
// types and constants of the tlv header walker
package tlvhw_pkg;

  localparam int unsigned FIELD_BYTES = 4;
  localparam int unsigned COUNT_W = 30;
  localparam int unsigned QUEUE_DEPTH = 3;

  typedef logic [1:0] tlvhw_kind_t;
  localparam tlvhw_kind_t K_RECORD = 2'd0;
  localparam tlvhw_kind_t K_OK = 2'd1;
  localparam tlvhw_kind_t K_SHORT = 2'd2;
  localparam tlvhw_kind_t K_MISALIGN = 2'd3;

  typedef enum logic [2:0] {
    PH_ID  = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } tlvhw_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } tlvhw_in_t;

  typedef struct packed {
    tlvhw_kind_t        kind;
    logic [31:0]        record_id;
    logic [31:0]        value_length;
    logic [31:0]        value_offset;
    logic [COUNT_W-1:0] record_count;
    logic               last_of_run;
  } tlvhw_out_t;

  // results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] num;
    tlvhw_out_t res0;
    tlvhw_out_t res1;
  } tlvhw_push_t;

endpackage

### hdl/tlvhw_walker.sv
// record walker: field assembly, record detection and region status
module tlvhw_walker import tlvhw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  tlvhw_in_t   in_item,
  output tlvhw_push_t push
);

  `include "tlv_header_walker_assert.svh"

  tlvhw_phase_t       phase_r, phase_nxt;
  logic [1:0]         fbc_r, fbc_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        remain_r, remain_nxt;
  logic [31:0]        offset_r, offset_nxt;
  logic [COUNT_W-1:0] seen_r, seen_nxt;

  logic [31:0] byte_sh;
  logic [31:0] len_new;
  logic [31:0] remain_dec;
  logic        rec_hit;
  logic [31:0] rec_len;
  tlvhw_out_t  rec_res;
  tlvhw_out_t  stat_res;

  assign byte_sh    = {24'd0, in_item.data_byte} << {fbc_r, 3'b000};
  assign len_new    = len_r | byte_sh;
  assign remain_dec = remain_r - 32'd1;

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    offset_nxt = offset_r;
    seen_nxt   = seen_r;
    rec_hit    = 1'b0;
    rec_len    = len_r;
    stat_res   = '0;
    push       = '0;

    if (accept && in_item.byte_valid) begin
      offset_nxt = offset_r + 32'd1;
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = len_new;
          if (fbc_r == 2'(FIELD_BYTES - 1)) begin
            fbc_nxt = 2'd0;
            if (len_new == 32'd0) begin
              rec_hit   = 1'b1;
              rec_len   = 32'd0;
              phase_nxt = PH_ID;
            end else begin
              remain_nxt = len_new;
              phase_nxt  = PH_VAL;
            end
          end else begin
            fbc_nxt = fbc_r + 2'd1;
          end
        end
        PH_VAL: begin
          remain_nxt = remain_dec;
          if (remain_dec == 32'd0) begin
            rec_hit   = 1'b1;
            phase_nxt = PH_ID;
          end
        end
        default: begin
          // id field; a fresh field starts from zero
          id_nxt = ((fbc_r == 2'd0) ? 32'd0 : id_r) | byte_sh;
          if (fbc_r == 2'(FIELD_BYTES - 1)) begin
            fbc_nxt   = 2'd0;
            len_nxt   = 32'd0;
            phase_nxt = PH_LEN;
          end else begin
            fbc_nxt   = fbc_r + 2'd1;
            phase_nxt = PH_ID;
          end
        end
      endcase
      if (rec_hit) begin
        seen_nxt = seen_r + COUNT_W'(1);
      end
    end

    rec_res.kind         = K_RECORD;
    rec_res.record_id    = id_r;
    rec_res.value_length = rec_len;
    rec_res.value_offset = offset_r + 32'd1 - rec_len;
    rec_res.record_count = seen_r;
    rec_res.last_of_run  = !in_item.last_byte;

    if (accept && in_item.last_byte) begin
      stat_res.last_of_run = 1'b1;
      if (phase_nxt == PH_VAL) begin
        stat_res.kind = K_MISALIGN;
      end else if (phase_nxt == PH_LEN || fbc_nxt != 2'd0) begin
        stat_res.kind = K_SHORT;
      end else begin
        stat_res.kind         = K_OK;
        stat_res.record_count = seen_nxt;
      end
      phase_nxt  = PH_ID;
      fbc_nxt    = 2'd0;
      id_nxt     = 32'd0;
      len_nxt    = 32'd0;
      remain_nxt = 32'd0;
      offset_nxt = 32'd0;
      seen_nxt   = '0;
    end

    if (rec_hit) begin
      push.res0 = rec_res;
      push.res1 = stat_res;
      push.num  = (accept && in_item.last_byte) ? 2'd2 : 2'd1;
    end else if (accept && in_item.last_byte) begin
      push.res0 = stat_res;
      push.num  = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ID;
      fbc_r    <= 2'd0;
      id_r     <= 32'd0;
      len_r    <= 32'd0;
      remain_r <= 32'd0;
      offset_r <= 32'd0;
      seen_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      offset_r <= offset_nxt;
      seen_r   <= seen_nxt;
    end
  end

  `TLV_ASSERT_NXT(a_reset_after_last, accept && in_item.last_byte,
                  phase_r == PH_ID && fbc_r == 2'd0 && offset_r == 32'd0 && seen_r == '0)
  `TLV_ASSERT_IMP(a_two_needs_last, push.num == 2'd2,
                  accept && in_item.byte_valid && in_item.last_byte)

endmodule

### hdl/tlvhw_result_queue.sv
// small result queue that parts the walker from the output channel
module tlvhw_result_queue import tlvhw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tlvhw_push_t push,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output tlvhw_out_t  out_data
);

  `include "tlv_header_walker_assert.svh"

  tlvhw_out_t q_r   [QUEUE_DEPTH];
  tlvhw_out_t q_nxt [QUEUE_DEPTH];
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] base;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = count_r - {1'b0, pop};
  // room for two results after this cycle's pop
  assign in_ready  = (count_r <= 2'd1) || (count_r == 2'd2 && out_ready);
  assign count_nxt = base + push.num;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push.num != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push.res0;
      end
      if (push.num == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `TLV_ASSERT_IMP(a_no_overflow, push.num != 2'd0,
                  ({1'b0, base} + {1'b0, push.num}) <= 3'(QUEUE_DEPTH))

endmodule

### hdl/tlv_header_walker.sv
// top level of the tlv header walker
// Takes one byte of a header region per cycle while in_ready is high and
// streams out one result per cycle while out_ready is high: a record result
// when a record's value completes (or on the last length byte for an empty
// value), and a status when last_byte arrives. Results pass through a
// three-entry queue, and in_ready drops only when that queue could not take
// two more results after this cycle's pop, so with out_ready high bytes flow
// at one per cycle, and a byte that yields both a record and the status puts
// two results in the queue. Record results precede the status and should be
// dropped by the consumer if the status is an error.
module tlv_header_walker import tlvhw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tlvhw_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tlvhw_out_t out_data
);

  tlvhw_push_t push;
  logic        accept;

  assign accept = in_valid && in_ready;

  tlvhw_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push)
  );

  tlvhw_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sim/tlv_header_walker_check.sv
// checker for the tlv header walker: predicts the results of each byte and compares
module tlv_header_walker_check import tlvhw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  tlvhw_in_t   in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  tlvhw_out_t  out_data,
  output int unsigned bad_results,
  output int unsigned results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // walker state as seen by the predictor
  tlvhw_phase_t       walk_phase;
  logic [1:0]         walk_fcnt;
  logic [31:0]        walk_id;
  logic [31:0]        walk_len;
  logic [31:0]        walk_left;
  logic [31:0]        walk_offset;
  logic [COUNT_W-1:0] walk_records;

  tlvhw_out_t  walk_results[$];
  tlvhw_out_t  want;
  int unsigned mismatch_total = 0;

  function automatic void clear_walk();
    walk_phase   = PH_ID;
    walk_fcnt    = '0;
    walk_id      = '0;
    walk_len     = '0;
    walk_left    = '0;
    walk_offset  = '0;
    walk_records = '0;
  endfunction

  function automatic void add_result(tlvhw_kind_t kind, logic [31:0] id, logic [31:0] len,
                                     logic [31:0] off, logic [COUNT_W-1:0] cnt);
    tlvhw_out_t r;
    r.kind         = kind;
    r.record_id    = id;
    r.value_length = len;
    r.value_offset = off;
    r.record_count = cnt;
    r.last_of_run  = 1'b0;
    walk_results.push_back(r);
  endfunction

  function automatic void walk_byte(tlvhw_in_t it);
    int unsigned made;
    logic [31:0] pos;
    logic [31:0] shifted;
    made    = walk_results.size();
    pos     = walk_offset;
    shifted = 32'(it.data_byte) << (8 * walk_fcnt);
    if (it.byte_valid) begin
      walk_offset = walk_offset + 32'd1;
      case (walk_phase)
        PH_LEN: begin
          walk_len = walk_len | shifted;
          if (walk_fcnt == 2'(FIELD_BYTES - 1)) begin
            walk_fcnt = '0;
            if (walk_len == '0) begin
              // empty value: record goes out on the last length byte
              add_result(K_RECORD, walk_id, '0, walk_offset, walk_records);
              walk_records = walk_records + 1'b1;
              walk_phase   = PH_ID;
            end else begin
              walk_left  = walk_len;
              walk_phase = PH_VAL;
            end
          end else begin
            walk_fcnt = walk_fcnt + 2'd1;
          end
        end
        PH_VAL: begin
          walk_left = walk_left - 32'd1;
          if (walk_left == '0) begin
            add_result(K_RECORD, walk_id, walk_len, pos + 32'd1 - walk_len, walk_records);
            walk_records = walk_records + 1'b1;
            walk_phase   = PH_ID;
          end
        end
        default: begin
          if (walk_fcnt == '0) walk_id = '0;
          walk_id = walk_id | shifted;
          if (walk_fcnt == 2'(FIELD_BYTES - 1)) begin
            walk_fcnt  = '0;
            walk_len   = '0;
            walk_phase = PH_LEN;
          end else begin
            walk_fcnt = walk_fcnt + 2'd1;
          end
        end
      endcase
    end
    if (it.last_byte) begin
      if (walk_phase == PH_VAL) begin
        add_result(K_MISALIGN, '0, '0, '0, '0);
      end else if (walk_phase == PH_LEN || walk_fcnt != '0) begin
        add_result(K_SHORT, '0, '0, '0, '0);
      end else begin
        add_result(K_OK, '0, '0, '0, walk_records);
      end
      clear_walk();
    end
    if (walk_results.size() > made) walk_results[$].last_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walk();
      walk_results.delete();
    end else begin
      // prediction first so a same-edge result would already be waiting
      if (in_valid && in_ready) walk_byte(in_data);
      if (out_valid && out_ready) begin
        if (walk_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display({"%0t: result with none expected: kind %0d id %h len %h",
                      " off %h cnt %0d last %b"},
                     $realtime, out_data.kind, out_data.record_id, out_data.value_length,
                     out_data.value_offset, out_data.record_count, out_data.last_of_run);
        end else begin
          want = walk_results.pop_front();
          if (out_data !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display({"%0t: mismatch (exp/got) kind %0d/%0d id %h/%h len %h/%h off %h/%h",
                        " cnt %0d/%0d last %b/%b"}, $realtime,
                       want.kind, out_data.kind, want.record_id, out_data.record_id,
                       want.value_length, out_data.value_length,
                       want.value_offset, out_data.value_offset,
                       want.record_count, out_data.record_count,
                       want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
    results_due <= walk_results.size();
    bad_results <= mismatch_total;
  end

endmodule

### sim/tlv_header_walker_test.sv
// testbench top for the tlv header walker: stimulus, handshake pressure and verdict
module tlv_header_walker_test;
  import tlvhw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_FROM = 370;
  localparam int unsigned ITEM_TOTAL = 420;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  tlvhw_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tlvhw_out_t out_data;

  int unsigned bad_results;
  int unsigned results_due;

  tlvhw_in_t   region_q[$];
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  always #2 clk = ~clk;

  tlv_header_walker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tlv_header_walker_check checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .bad_results (bad_results),
    .results_due (results_due)
  );

  function automatic tlvhw_in_t mk(logic [7:0] b, logic v, logic l);
    tlvhw_in_t it;
    it.data_byte  = b;
    it.byte_valid = v;
    it.last_byte  = l;
    return it;
  endfunction

  function automatic void push_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) region_q.push_back(mk(w[8*i +: 8], 1'b1, 1'b0));
  endfunction

  // whole records with random ids, mostly short values
  function automatic void push_records(int unsigned count);
    logic [31:0] len;
    for (int unsigned r = 0; r < count; r++) begin
      case ($urandom_range(0, 7))
        0, 1:    len = 32'd0;
        2:       len = $urandom_range(7, 40);
        default: len = $urandom_range(1, 6);
      endcase
      push_word($urandom);
      push_word(len);
      for (int unsigned i = 0; i < len; i++)
        region_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
    end
  endfunction

  // mark the end of the region, or make it an empty region
  function automatic void close_region();
    if (region_q.size() == 0) region_q.push_back(mk(8'($urandom), 1'b0, 1'b1));
    else region_q[$].last_byte = 1'b1;
  endfunction

  task automatic send_item(tlvhw_in_t it);
    if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_region();
    foreach (region_q[i]) begin
      // stray idle transactions that the walker must ignore
      if ($urandom_range(0, 19) == 0) send_item(mk(8'($urandom), 1'b0, 1'b0));
      send_item(region_q[i]);
      bytes_sent++;
    end
    region_q.delete();
  endtask

  task automatic make_random_region();
    int unsigned pick;
    logic [31:0] len;
    int unsigned keep;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      push_records($urandom_range(0, 4));
      close_region();
    end else if (pick < 80) begin
      // truncated before its end: inside a field, a value or between records
      push_records($urandom_range(1, 3));
      keep = $urandom_range(1, region_q.size() - 1);
      region_q = region_q[0:keep-1];
      close_region();
    end else if (pick < 88) begin
      // length far beyond the end of the region
      push_records($urandom_range(0, 1));
      len = $urandom;
      if (len < 32'd8) len = len + 32'd8;
      push_word($urandom);
      push_word(len);
      repeat ($urandom_range(0, 5)) region_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
      close_region();
    end else if (pick < 95) begin
      // region closed by a status transaction that carries no byte
      push_records($urandom_range(0, 2));
      repeat ($urandom_range(0, 6)) region_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
      region_q.push_back(mk(8'($urandom), 1'b0, 1'b1));
    end else begin
      close_region();
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty region, idle transaction, empty value closing the region
    region_q.push_back(mk(8'hff, 1'b0, 1'b1));
    region_q.push_back(mk(8'h00, 1'b0, 1'b0));
    push_word(32'hffff_ffff);
    push_word(32'h0000_0000);
    close_region();
    send_region();
    // short metadata via status with no byte, then a misaligned value
    region_q.push_back(mk(8'h00, 1'b1, 1'b0));
    region_q.push_back(mk(8'hff, 1'b1, 1'b0));
    region_q.push_back(mk(8'h00, 1'b0, 1'b1));
    push_word(32'h0000_0001);
    push_word(32'hffff_ffff);
    close_region();
    send_region();

    while (bytes_sent < ITEM_TOTAL) begin
      if (bytes_sent >= 120 && !hold_req) hold_req = 1'b1;
      if (bytes_sent >= 280 && !paused) begin
        // hold the sender until the walker has drained
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
      end
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
      make_random_region();
      send_region();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);
    if (bad_results == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
